// ----- rtl/core/eta_pkg.sv -----
// shared constants, types and helper functions of the texel address unit
`default_nettype none

package eta_pkg;

  localparam int IN_W           = 16;
  localparam int DIM_W          = 13;
  localparam int COL_W          = 12;
  localparam int IDX_W          = 24;
  localparam int ADDR_W         = 3;
  localparam int MAX_DIM        = 4096;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int IN_SCALE       = 14;
  localparam int SQ_W           = 2 * IN_W;
  localparam int RAD_W          = SQ_W + 2 * IN_SCALE;
  localparam int SQRT_BITS      = RAD_W / 2;
  localparam int CORDIC_STEPS   = 24;
  localparam int CW             = 34;
  localparam int ACC_W          = 34;

  localparam logic signed [ACC_W-1:0] HALF_TURN    = ACC_W'(1) << 31;
  localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(1) << 30;

  typedef enum logic {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [CW-1:0]    n;
    logic signed [CW-1:0]    d;
    logic signed [ACC_W-1:0] a;
    logic                    ovr;
  } cordic_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [31:0] step_angle(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10679838;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // exact angles on the axes, quarter-turn pre-rotation into the right half plane
  function automatic cordic_t cordic_init(input logic signed [CW-1:0] num,
                                          input logic signed [CW-1:0] den);
    cordic_t r;
    r.n   = num;
    r.d   = den;
    r.a   = '0;
    r.ovr = 1'b0;
    if (num == '0) begin
      r.ovr = 1'b1;
      r.a   = den[CW-1] ? HALF_TURN : '0;
    end else if (den == '0) begin
      r.ovr = 1'b1;
      r.a   = num[CW-1] ? -QUARTER_TURN : QUARTER_TURN;
    end else if (den[CW-1]) begin
      if (!num[CW-1]) begin
        r.a = QUARTER_TURN;
        r.d = num;
        r.n = -den;
      end else begin
        r.a = -QUARTER_TURN;
        r.d = -num;
        r.n = den;
      end
    end
    return r;
  endfunction

  // one vectoring micro-rotation, shifts round toward minus infinity
  function automatic cordic_t cordic_step(input cordic_t s, input int unsigned i);
    logic signed [CW-1:0]    dx;
    logic signed [CW-1:0]    dy;
    logic signed [ACC_W-1:0] st;
    cordic_t r;
    dx = s.d >>> i;
    dy = s.n >>> i;
    st = $signed(ACC_W'(step_angle(i)));
    r  = s;
    if (!s.ovr) begin
      if (!s.n[CW-1]) begin
        r.d = s.d + dy;
        r.n = s.n - dx;
        r.a = s.a + st;
      end else begin
        r.d = s.d - dy;
        r.n = s.n + dx;
        r.a = s.a - st;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/eta_dir_if.sv -----
// direction channel: valid/ready with the three direction components
`default_nettype none

interface eta_dir_if import eta_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  dir_x;
  logic signed [IN_W-1:0]  dir_y;
  logic signed [IN_W-1:0]  dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/eta_texel_if.sv -----
// texel channel: valid/ready with column, row, linear index and map flag
`default_nettype none

interface eta_texel_if import eta_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] texel_col;
  logic [COL_W-1:0] texel_row;
  logic [IDX_W-1:0] texel_index;
  logic             valid_res;

  modport source (output valid, output texel_col, output texel_row, output texel_index,
                  output valid_res, input ready);
  modport sink   (input valid, input texel_col, input texel_row, input texel_index,
                  input valid_res, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/equirect_texel_address.sv -----
// Equirectangular direction to texel address unit.
// A direction (dir_x, dir_y, dir_z, signed, y up) arrives on dir_i; one texel result
// leaves on texel_o for every direction, in order. Both channels transfer on valid & ready.
// Map width and height are APB registers at byte addresses 0 and 4 (reset 64 and 32);
// write them only while no direction is in flight. A zero dimension gives valid_res = 0.
// Throughput: one direction per cycle while the receiver takes results. The pipeline
// is the 30-stage bit-per-stage square root of x*x + z*z followed by the 24-stage
// CORDIC that turns both vectors into angles, plus squaring, scaling and address stages.
// The whole pipeline advances together whenever the output register is empty or being
// taken; when the receiver stalls with a result waiting, every stage holds and dir_i.ready
// drops, so nothing is lost or repeated. Bubbles travel as cleared valid bits.
// Reset clears all valid bits and loads the register defaults; pready is tied high.
`default_nettype none

module equirect_texel_address import eta_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  eta_dir_if.sink           dir_i,
  eta_texel_if.source       texel_o
);

  localparam int AF_W   = ANGLE_BITS + 1;
  localparam int PROD_W = AF_W + DIM_W;
  localparam int NSTG   = 2 + (SQRT_BITS + 1) + (CORDIC_STEPS + 1) + 4;

  // configuration
  logic [DIM_W-1:0] map_width_q, map_height_q;
  logic [DIM_W-1:0] wc, hc;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= DIM_W'(64);
      map_height_q <= DIM_W'(32);
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[2]))
        REG_MAP_WIDTH:  map_width_q  <= pwdata[DIM_W-1:0];
        REG_MAP_HEIGHT: map_height_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_MAP_WIDTH:  prdata = 32'(map_width_q);
      REG_MAP_HEIGHT: prdata = 32'(map_height_q);
      default:        prdata = '0;
    endcase
  end

  assign wc = (map_width_q  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : map_width_q;
  assign hc = (map_height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : map_height_q;

  // pipeline control
  logic            adv;
  logic [NSTG-1:0] vld_q;
  logic            out_vld_q;

  assign adv         = !out_vld_q || texel_o.ready;
  assign dir_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NSTG-2:0], dir_i.valid};
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  // input register and squares
  logic signed [IN_W-1:0] x0_q, y0_q, z0_q, x1_q, y1_q, z1_q;
  logic [SQ_W-2:0]        xx1_q, zz1_q;
  logic signed [SQ_W-1:0] xx_full, zz_full;

  assign xx_full = x0_q * x0_q;
  assign zz_full = z0_q * z0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q  <= dir_i.dir_x;
      y0_q  <= dir_i.dir_y;
      z0_q  <= dir_i.dir_z;
      x1_q  <= x0_q;
      y1_q  <= y0_q;
      z1_q  <= z0_q;
      xx1_q <= xx_full[SQ_W-2:0];
      zz1_q <= zz_full[SQ_W-2:0];
    end
  end

  // square root of (x*x + z*z) << 28, one result bit per stage
  logic [RAD_W-1:0]       sq_rem_q  [SQRT_BITS+1];
  logic [SQRT_BITS-1:0]   sq_root_q [SQRT_BITS+1];
  logic signed [IN_W-1:0] sq_x_q    [SQRT_BITS+1];
  logic signed [IN_W-1:0] sq_y_q    [SQRT_BITS+1];
  logic signed [IN_W-1:0] sq_z_q    [SQRT_BITS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rem_q[0]  <= {(SQ_W'(xx1_q) + SQ_W'(zz1_q)), (2 * IN_SCALE)'(0)};
      sq_root_q[0] <= '0;
      sq_x_q[0]    <= x1_q;
      sq_y_q[0]    <= y1_q;
      sq_z_q[0]    <= z1_q;
    end
  end

  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
    localparam int B = SQRT_BITS - 1 - k;
    logic [RAD_W-1:0] trial;
    logic             take;

    assign trial = (RAD_W'(sq_root_q[k]) << (B + 1)) + (RAD_W'(1) << (2 * B));
    assign take  = sq_rem_q[k] >= trial;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[k+1]  <= take ? (sq_rem_q[k] - trial) : sq_rem_q[k];
        sq_root_q[k+1] <= take ? (sq_root_q[k] | (SQRT_BITS'(1) << B)) : sq_root_q[k];
        sq_x_q[k+1]    <= sq_x_q[k];
        sq_y_q[k+1]    <= sq_y_q[k];
        sq_z_q[k+1]    <= sq_z_q[k];
      end
    end
  end

  // CORDIC for azimuth (x against z) and polar angle (r against y)
  cordic_t ph_q [CORDIC_STEPS+1];
  cordic_t th_q [CORDIC_STEPS+1];
  logic    zd_q [CORDIC_STEPS+1];

  logic signed [CW-1:0] xs, ys, zs, rs;

  assign xs = CW'(sq_x_q[SQRT_BITS]) <<< IN_SCALE;
  assign ys = CW'(sq_y_q[SQRT_BITS]) <<< IN_SCALE;
  assign zs = CW'(sq_z_q[SQRT_BITS]) <<< IN_SCALE;
  assign rs = $signed(CW'(sq_root_q[SQRT_BITS]));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_q[0] <= cordic_init(xs, zs);
      th_q[0] <= cordic_init(rs, ys);
      zd_q[0] <= (xs == '0) && (ys == '0) && (zs == '0);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ph_q[i+1] <= cordic_step(ph_q[i], i);
        th_q[i+1] <= cordic_step(th_q[i], i);
        zd_q[i+1] <= zd_q[i];
      end
    end
  end

  // angles to fractions
  logic signed [ACC_W-1:0] phc, thc, usum;
  logic [AF_W-1:0]         u_fix, v_fix, u1_q, v1_q;

  always_comb begin
    phc = ph_q[CORDIC_STEPS].a;
    if (phc > HALF_TURN) phc = HALF_TURN;
    if (phc < -HALF_TURN) phc = -HALF_TURN;
    thc = th_q[CORDIC_STEPS].a;
    if (thc > HALF_TURN) thc = HALF_TURN;
    if (thc[ACC_W-1]) thc = '0;
    usum  = phc + HALF_TURN;
    u_fix = usum[32 -: AF_W];
    v_fix = thc[31 -: AF_W];
    if (zd_q[CORDIC_STEPS]) begin
      u_fix = AF_W'(1) << (ANGLE_BITS - 1);
      v_fix = AF_W'(1) << (ANGLE_BITS - 1);
    end
  end

  // scaling to the map, wrap and clamp, linear address
  logic [PROD_W-1:0] pu2_q, pv2_q;
  logic [DIM_W-1:0]  col_full, row_full;
  logic [COL_W-1:0]  col3_q, row3_q, col4_q, row4_q;
  logic [IDX_W-1:0]  rw4_q;
  logic [DIM_W+COL_W-1:0] rw_full;

  assign col_full = pu2_q[ANGLE_BITS +: DIM_W];
  assign row_full = pv2_q[ANGLE_BITS +: DIM_W];
  assign rw_full  = (DIM_W + COL_W)'(row3_q) * (DIM_W + COL_W)'(wc);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u1_q   <= u_fix;
      v1_q   <= v_fix;
      pu2_q  <= PROD_W'(u1_q) * PROD_W'(wc);
      pv2_q  <= PROD_W'(v1_q) * PROD_W'(hc);
      // azimuth of exactly a half turn lands on the width and wraps to column zero
      col3_q <= (col_full == wc) ? '0 : COL_W'(col_full);
      row3_q <= (row_full >= hc) ? COL_W'(hc - DIM_W'(1)) : COL_W'(row_full);
      col4_q <= col3_q;
      row4_q <= row3_q;
      rw4_q  <= rw_full[IDX_W-1:0];
    end
  end

  // output register
  logic             no_map;
  logic [COL_W-1:0] out_col_q, out_row_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_res_q;

  assign no_map = (wc == '0) || (hc == '0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_col_q <= no_map ? '0 : col4_q;
      out_row_q <= no_map ? '0 : row4_q;
      out_idx_q <= no_map ? '0 : (rw4_q + IDX_W'(col4_q));
      out_res_q <= !no_map;
    end
  end

  assign texel_o.valid       = out_vld_q;
  assign texel_o.texel_col   = out_col_q;
  assign texel_o.texel_row   = out_row_q;
  assign texel_o.texel_index = out_idx_q;
  assign texel_o.valid_res   = out_res_q;

  // assertions
  a_no_map_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    texel_o.valid && !texel_o.valid_res |->
      texel_o.texel_col == '0 && texel_o.texel_row == '0 && texel_o.texel_index == '0)
    else $error("no-map result carries a nonzero address");

  a_col_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    texel_o.valid && texel_o.valid_res |-> DIM_W'(texel_o.texel_col) < wc)
    else $error("column outside map width");

  a_row_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    texel_o.valid && texel_o.valid_res |-> DIM_W'(texel_o.texel_row) < hc)
    else $error("row outside map height");

endmodule

`default_nettype wire
